>>> sv/ssms_pkg.sv
`default_nettype none
package ssms_pkg;

  localparam int CAPACITY  = 1024;
  localparam int COORD_W   = 20;
  localparam int VALUE_W   = 32;
  localparam int KEY_W     = 2 * COORD_W;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CFG_W     = COORD_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(1 << COORD_W);

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic load;         // latch request, open search window
    logic srch_rd;      // read the midpoint
    logic srch_cmp;     // narrow the window
    logic chk_rd;       // read the slot found by the search
    logic chk_cmp;      // exact-match test
    logic shift_start;  // point at the last entry
    logic shift_rd;     // read one entry to move up
    logic ins;          // write the new entry
    logic upd;          // overwrite value of an existing entry
    logic res_load;     // load the result register
  } ssms_cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic found;
    logic pos_lt_count;
    logic shift_last;
    logic full;
    logic range_err;
    logic query;
    logic is_write;
    logic out_busy;
  } ssms_sts_t;

endpackage
`default_nettype wire

>>> sv/ssms_ctrl.sv
`default_nettype none
module ssms_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ssms_pkg::ssms_sts_t sts,
  output ssms_pkg::ssms_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_SCMP  = 4'd2;
  localparam logic [3:0] S_CCMP  = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_SHIFT = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_INS   = 4'd7;
  localparam logic [3:0] S_RES   = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (sts.lo_lt_hi) begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SCMP;
        end else begin
          cmd.chk_rd = 1'b1;
          state_nxt  = S_CCMP;
        end
      end
      S_SCMP: begin
        cmd.srch_cmp = 1'b1;
        state_nxt    = S_SRCH;
      end
      S_CCMP: begin
        cmd.chk_cmp = 1'b1;
        state_nxt   = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_RES;
        if (!sts.query && !sts.range_err) begin
          if (sts.found) begin
            cmd.upd = sts.is_write;
          end else if (!sts.full) begin
            if (sts.pos_lt_count) begin
              cmd.shift_start = 1'b1;
              state_nxt       = S_SHIFT;
            end else begin
              cmd.ins = 1'b1;
            end
          end
        end
      end
      S_SHIFT: begin
        cmd.shift_rd = 1'b1;
        if (sts.shift_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // last moved entry is written here by the datapath
        state_nxt = S_INS;
      end
      S_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/ssms_dp.sv
`default_nettype none
module ssms_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [ssms_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [ssms_pkg::CFG_W-1:0]             cfg_wdata,
  input  wire logic [ssms_pkg::FUNC_W-1:0]            in_func,
  input  wire logic [ssms_pkg::COORD_W-1:0]           in_row_index,
  input  wire logic [ssms_pkg::COORD_W-1:0]           in_column_index,
  input  wire logic signed [ssms_pkg::VALUE_W-1:0]    in_write_value,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [ssms_pkg::VALUE_W-1:0]         out_read_value,
  output logic                                        out_present,
  output logic [ssms_pkg::STATUS_W-1:0]               out_status,
  input  wire ssms_pkg::ssms_cmd_t                    cmd,
  output ssms_pkg::ssms_sts_t                         sts
);

  localparam int AW = ssms_pkg::ADDR_W;
  localparam int CW = ssms_pkg::CNT_W;
  localparam int KW = ssms_pkg::KEY_W;
  localparam int VW = ssms_pkg::VALUE_W;
  localparam int DW = ssms_pkg::COORD_W;

  ssms_pkg::entry_t mem [ssms_pkg::CAPACITY];

  logic [ssms_pkg::CFG_W-1:0]  row_count_r, col_count_r;
  logic [ssms_pkg::FUNC_W-1:0] func_r;
  logic [KW-1:0]               key_r;
  logic [VW-1:0]               wv_r;
  logic [CW-1:0]               lo_r, hi_r, count_r;
  logic [AW-1:0]               mid_r, sidx_r, rd_addr_q_r;
  logic                        found_r, wr_pend_r, full_r;
  logic [VW-1:0]               val_r;
  ssms_pkg::entry_t            rdata_r;

  logic                        out_valid_r, out_present_r;
  logic [VW-1:0]               out_value_r;
  logic [ssms_pkg::STATUS_W-1:0] out_status_r;

  logic [CW:0]      mid_sum;
  logic [AW-1:0]    mid_w, rd_addr, wr_addr;
  logic             mem_we;
  ssms_pkg::entry_t wr_data;
  logic             query, range_err, full, pos_lt_count;

  assign mid_sum      = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w        = mid_sum[AW:1];
  assign query        = func_r[1];
  assign range_err    = ({1'b0, key_r[KW-1:DW]} >= row_count_r) ||
                        ({1'b0, key_r[DW-1:0]} >= col_count_r);
  assign full         = (count_r == CW'(ssms_pkg::CAPACITY));
  assign pos_lt_count = (lo_r < count_r);

  // memory ports
  always_comb begin
    rd_addr = mid_w;
    priority if (cmd.chk_rd)   rd_addr = lo_r[AW-1:0];
    else if (cmd.shift_rd)     rd_addr = sidx_r;
    else                       rd_addr = mid_w;
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = lo_r[AW-1:0];
    wr_data = rdata_r;
    priority if (wr_pend_r) begin
      // entry read last cycle moves up one slot
      mem_we  = 1'b1;
      wr_addr = rd_addr_q_r + AW'(1);
      wr_data = rdata_r;
    end else if (cmd.ins) begin
      mem_we        = 1'b1;
      wr_data.key   = key_r;
      wr_data.value = (func_r == ssms_pkg::FUNC_WRITE) ? wv_r : '0;
    end else if (cmd.upd) begin
      mem_we        = 1'b1;
      wr_data.key   = key_r;
      wr_data.value = wv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  // request and search registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r  <= {in_row_index, in_column_index};
      wv_r   <= in_write_value;
      lo_r   <= '0;
      hi_r   <= count_r;
    end
    if (cmd.srch_rd) mid_r <= mid_w;
    if (cmd.srch_cmp) begin
      if (rdata_r.key < key_r) lo_r <= CW'(mid_r) + CW'(1);
      else                     hi_r <= CW'(mid_r);
    end
    if (cmd.chk_cmp) begin
      found_r <= pos_lt_count && (rdata_r.key == key_r);
      val_r   <= rdata_r.value;
      // table fill as seen before this request inserts anything
      full_r  <= full;
    end
    if (cmd.shift_start) sidx_r <= AW'(count_r - CW'(1));
    else if (cmd.shift_rd) sidx_r <= sidx_r - AW'(1);
    if (cmd.shift_rd) rd_addr_q_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      row_count_r <= ssms_pkg::DIM_RESET;
      col_count_r <= ssms_pkg::DIM_RESET;
    end else begin
      wr_pend_r <= cmd.shift_rd;
      if (cmd.ins) count_r <= count_r + CW'(1);
      if (cfg_we) begin
        unique case (cfg_index)
          ssms_pkg::CFG_ROW_COUNT:    row_count_r <= cfg_wdata;
          ssms_pkg::CFG_COLUMN_COUNT: col_count_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      priority if (query) begin
        out_value_r   <= found_r ? val_r : '0;
        out_present_r <= found_r;
        out_status_r  <= ssms_pkg::STATUS_OK;
      end else if (range_err) begin
        out_value_r   <= '0;
        out_present_r <= 1'b0;
        out_status_r  <= ssms_pkg::STATUS_RANGE;
      end else if (!found_r && full_r) begin
        out_value_r   <= '0;
        out_present_r <= 1'b0;
        out_status_r  <= ssms_pkg::STATUS_FULL;
      end else begin
        out_value_r   <= (func_r == ssms_pkg::FUNC_WRITE) ? wv_r :
                         (found_r ? val_r : '0);
        out_present_r <= found_r;
        out_status_r  <= ssms_pkg::STATUS_OK;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_present    = out_present_r;
  assign out_status     = out_status_r;

  always_comb begin
    sts              = '0;
    sts.lo_lt_hi     = (lo_r < hi_r);
    sts.found        = found_r;
    sts.pos_lt_count = pos_lt_count;
    sts.shift_last   = (CW'(sidx_r) == lo_r);
    sts.full         = full;
    sts.range_err    = range_err;
    sts.query        = query;
    sts.is_write     = (func_r == ssms_pkg::FUNC_WRITE);
    sts.out_busy     = out_valid_r && !out_ready;
  end

endmodule
`default_nettype wire

>>> sv/sorted_sparse_matrix_store.sv
// Sparse matrix store: up to 1024 (row, column, value) entries kept sorted by key
// in a single-port-write, single-port-read table.
// Input channel (in_*): one request beat carries func (0 read, 1 write, 2/3 query),
// row and column index and a write value. Output channel (out_*): one result beat
// per request with the value, a present flag and a status (ok, range, full).
// Configuration (cfg_*): row_count at index 0, column_count at index 1; write only
// while no request is in flight.
// One request at a time. From accept to out_valid a request runs a binary search
//   of up to 11 steps, an exact-match check and, for an insert, a shift of the
//   entries above the insert slot (up to 1023). Each search step is a
//   memory read then a compare; the shift moves one entry per cycle through the
//   table's one read and one write port.
// in_ready is high only while idle. The result sits in an output register; a
// new request is taken while it waits, but that request's result is held back
// until the previous beat is taken.
// Reset (synchronous, rst_n low) empties the table and sets both dimensions to
// 2^20; table contents are not cleared, no clearing pass is needed.
`default_nettype none
module sorted_sparse_matrix_store (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [ssms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ssms_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [ssms_pkg::FUNC_W-1:0]         in_func,
  input  wire logic [ssms_pkg::COORD_W-1:0]        in_row_index,
  input  wire logic [ssms_pkg::COORD_W-1:0]        in_column_index,
  input  wire logic signed [ssms_pkg::VALUE_W-1:0] in_write_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [ssms_pkg::VALUE_W-1:0]      out_read_value,
  output logic                                     out_present,
  output logic [ssms_pkg::STATUS_W-1:0]            out_status
);

  ssms_pkg::ssms_cmd_t cmd;
  ssms_pkg::ssms_sts_t sts;

  ssms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssms_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_func         (in_func),
    .in_row_index    (in_row_index),
    .in_column_index (in_column_index),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_present     (out_present),
    .out_status      (out_status),
    .cmd             (cmd),
    .sts             (sts)
  );

  // one request in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // an error result never reports an existing entry
  a_err_not_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ssms_pkg::STATUS_OK) |-> !out_present)
    else $error("error result flagged present");

  // a new result beat only comes from the result load
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.res_load))
    else $error("out_valid raised without a result load");

  // a table change only happens while a request is being handled
  a_ins_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ins || cmd.upd) |-> !in_ready && !sts.query && !sts.range_err)
    else $error("table written outside a read or write request");

endmodule
`default_nettype wire
